>>> rtl/tfn_pkg.sv
// tfn_pkg: request types shared by the triangle face normal block
// no dependencies

package tfn_pkg;

  localparam int FIELD_W  = 24;
  localparam int NORMAL_W = 16;
  localparam int ALIGN_W  = 31;
  localparam int ROOT_W   = 32;
  localparam int SUMSQ_W  = 64;

  typedef struct packed {
    logic signed [FIELD_W-1:0] a_x;
    logic signed [FIELD_W-1:0] a_y;
    logic signed [FIELD_W-1:0] a_z;
    logic signed [FIELD_W-1:0] b_x;
    logic signed [FIELD_W-1:0] b_y;
    logic signed [FIELD_W-1:0] b_z;
    logic signed [FIELD_W-1:0] c_x;
    logic signed [FIELD_W-1:0] c_y;
    logic signed [FIELD_W-1:0] c_z;
    logic                      end_of_mesh;
  } tri_req_t;

  typedef struct packed {
    logic signed [NORMAL_W-1:0] normal_x;
    logic signed [NORMAL_W-1:0] normal_y;
    logic signed [NORMAL_W-1:0] normal_z;
    logic                       degenerate;
    logic                       mesh_done;
  } nrm_req_t;

endpackage

>>> rtl/tfn_cross.sv
// tfn_cross: edge vectors, cross product and per-component magnitude
// four register stages, depends on tfn_pkg

module tfn_cross
  import tfn_pkg::*;
#(
  parameter int C  = 24,
  parameter int MW = 51,
  parameter int SW = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_vld,
  input  logic [8:0][C-1:0]        crd,
  input  logic [SW-1:0]            in_side,
  output logic                     out_vld,
  output logic [2:0][MW-1:0]       mag,
  output logic [2:0]               neg,
  output logic [SW-1:0]            out_side
);

  logic signed [C:0]      u_r [3];
  logic signed [C:0]      v_r [3];
  logic signed [2*C+1:0]  pr_r [6];
  logic signed [MW-1:0]   cr_r [3];
  logic [2:0][MW-1:0]     mag_r;
  logic [2:0]             neg_r;
  logic [3:0]             vld_r;
  logic [SW-1:0]          sd1_r, sd2_r, sd3_r, sd4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= (C+1)'($signed(crd[3+i])) - (C+1)'($signed(crd[i]));
        v_r[i] <= (C+1)'($signed(crd[6+i])) - (C+1)'($signed(crd[i]));
      end
      pr_r[0] <= u_r[1] * v_r[2];
      pr_r[1] <= u_r[2] * v_r[1];
      pr_r[2] <= u_r[2] * v_r[0];
      pr_r[3] <= u_r[0] * v_r[2];
      pr_r[4] <= u_r[0] * v_r[1];
      pr_r[5] <= u_r[1] * v_r[0];
      for (int i = 0; i < 3; i++) begin
        cr_r[i] <= MW'(pr_r[2*i]) - MW'(pr_r[2*i+1]);
        neg_r[i] <= cr_r[i][MW-1];
        mag_r[i] <= cr_r[i][MW-1] ? MW'(-cr_r[i]) : MW'(cr_r[i]);
      end
      sd1_r <= in_side;
      sd2_r <= sd1_r;
      sd3_r <= sd2_r;
      sd4_r <= sd3_r;
    end
  end

  assign out_vld  = vld_r[3];
  assign mag      = mag_r;
  assign neg      = neg_r;
  assign out_side = sd4_r;

endmodule

>>> rtl/tfn_align.sv
// tfn_align: leading-one search, common alignment to bit 30, sum of squares
// five register stages, depends on tfn_pkg

module tfn_align
  import tfn_pkg::*;
#(
  parameter int MW = 51,
  parameter int SW = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_vld,
  input  logic [2:0][MW-1:0]        mag,
  input  logic [SW-1:0]             in_side,
  output logic                      out_vld,
  output logic [2:0][ALIGN_W-1:0]   m,
  output logic [SUMSQ_W-1:0]        sum_sq,
  output logic                      zero,
  output logic [SW-1:0]             out_side
);

  localparam int NG = (MW + 7) / 8;
  localparam int OW = NG * 8;
  localparam int GW = $clog2(NG);
  localparam int PW = GW + 3;
  localparam int XW = MW + ALIGN_W;

  logic [4:0]                  vld_r;
  logic [SW-1:0]               sd_r [5];
  logic [OW-1:0]               orv_r;
  logic [NG-1:0]               flg_r;
  logic [2:0][MW-1:0]          mag1_r, mag2_r;
  logic [PW-1:0]               p2_r;
  logic                        nz2_r, nz3_r, nz4_r, nz5_r;
  logic [2:0][ALIGN_W-1:0]     m3_r, m4_r, m5_r, m3_nxt;
  logic [2:0][2*ALIGN_W-1:0]   sq4_r;
  logic [SUMSQ_W-1:0]          sum5_r;
  logic [OW-1:0]               orv_nxt;
  logic [GW-1:0]               gsel;
  logic [2:0]                  bsel;
  logic [7:0]                  grp;
  logic [XW-1:0]               ext, shv;

  always_comb begin
    orv_nxt = OW'(mag[0] | mag[1] | mag[2]);
  end

  // top group, then top bit inside it
  always_comb begin
    gsel = '0;
    for (int g = 0; g < NG; g++) begin
      if (flg_r[g]) gsel = GW'(g);
    end
    grp  = orv_r[gsel*8 +: 8];
    bsel = '0;
    for (int b = 0; b < 8; b++) begin
      if (grp[b]) bsel = 3'(b);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext = XW'(mag2_r[i]);
      if (int'(p2_r) >= ALIGN_W - 1) begin
        shv = ext >> (int'(p2_r) - (ALIGN_W - 1));
      end else begin
        shv = ext << ((ALIGN_W - 1) - int'(p2_r));
      end
      m3_nxt[i] = nz2_r ? shv[ALIGN_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      orv_r <= orv_nxt;
      for (int g = 0; g < NG; g++) flg_r[g] <= |orv_nxt[g*8 +: 8];
      mag1_r <= mag;
      p2_r   <= {gsel, bsel};
      nz2_r  <= |flg_r;
      mag2_r <= mag1_r;
      m3_r   <= m3_nxt;
      nz3_r  <= nz2_r;
      for (int i = 0; i < 3; i++) sq4_r[i] <= m3_r[i] * m3_r[i];
      m4_r   <= m3_r;
      nz4_r  <= nz3_r;
      sum5_r <= SUMSQ_W'(sq4_r[0]) + SUMSQ_W'(sq4_r[1]) + SUMSQ_W'(sq4_r[2]);
      m5_r   <= m4_r;
      nz5_r  <= nz4_r;
      sd_r[0] <= in_side;
      for (int k = 1; k < 5; k++) sd_r[k] <= sd_r[k-1];
    end
  end

  assign out_vld  = vld_r[4];
  assign m        = m5_r;
  assign sum_sq   = sum5_r;
  assign zero     = !nz5_r;
  assign out_side = sd_r[4];

endmodule

>>> rtl/tfn_sqrt.sv
// tfn_sqrt: pipelined integer square root, one result bit per stage
// depends on tfn_pkg

module tfn_sqrt
  import tfn_pkg::*;
#(
  parameter int SW = 98
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_vld,
  input  logic [SUMSQ_W-1:0]    sum_sq,
  input  logic [SW-1:0]         in_side,
  output logic                  out_vld,
  output logic [ROOT_W-1:0]     root,
  output logic [SW-1:0]         out_side
);

  localparam int RW = ROOT_W + 2;

  logic [RW-1:0]      rem_r  [ROOT_W];
  logic [ROOT_W-1:0]  root_r [ROOT_W];
  logic [SUMSQ_W-1:0] s_r    [ROOT_W];
  logic [SW-1:0]      sd_r   [ROOT_W];
  logic [ROOT_W-1:0]  vld_r;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [RW-1:0]      rem_i, rt, tr;
    logic [ROOT_W-1:0]  root_i;
    logic [SUMSQ_W-1:0] s_i;
    logic [SW-1:0]      sd_i;
    logic               v_i;
    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign s_i    = sum_sq;
      assign sd_i   = in_side;
      assign v_i    = in_vld;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign s_i    = s_r[k-1];
      assign sd_i   = sd_r[k-1];
      assign v_i    = vld_r[k-1];
    end
    assign rt = {rem_i[RW-3:0], s_i[SUMSQ_W-1 -: 2]};
    assign tr = {root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (rt >= tr) begin
          rem_r[k]  <= rt - tr;
          root_r[k] <= {root_i[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rt;
          root_r[k] <= {root_i[ROOT_W-2:0], 1'b0};
        end
        s_r[k]  <= s_i << 2;
        sd_r[k] <= sd_i;
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign root     = root_r[ROOT_W-1];
  assign out_side = sd_r[ROOT_W-1];

endmodule

>>> rtl/tfn_div.sv
// tfn_div: three-lane pipelined restoring divider, rounded m / length
// one quotient bit per stage, depends on tfn_pkg

module tfn_div
  import tfn_pkg::*;
#(
  parameter int F  = 14,
  parameter int SW = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_vld,
  input  logic [2:0][ALIGN_W-1:0]  m,
  input  logic [ROOT_W-1:0]        len,
  input  logic [SW-1:0]            in_side,
  output logic                     out_vld,
  output logic [2:0][F:0]          quo,
  output logic [SW-1:0]            out_side
);

  localparam int QB = F + 1;
  localparam int NW = ALIGN_W + QB + 1;
  localparam int RW = ROOT_W + 2;
  localparam int DW = ROOT_W + 1;

  logic [2:0][RW-1:0]  rem_r [QB+1];
  logic [2:0][QB-1:0]  low_r [QB+1];
  logic [2:0][QB-1:0]  q_r   [QB+1];
  logic [DW-1:0]       d_r   [QB+1];
  logic [SW-1:0]       sd_r  [QB+1];
  logic [QB:0]         vld_r;
  logic [2:0][NW-1:0]  num;

  // numerator m * 2^(F+1) + len, divisor 2 * len
  always_comb begin
    for (int i = 0; i < 3; i++) num[i] = (NW'(m[i]) << QB) + NW'(len);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= RW'(num[i][NW-1:QB]);
        low_r[0][i] <= num[i][QB-1:0];
        q_r[0][i]   <= '0;
      end
      d_r[0]  <= {len, 1'b0};
      sd_r[0] <= in_side;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_step
    logic [2:0][RW-1:0] rt;
    always_comb begin
      for (int i = 0; i < 3; i++) rt[i] = {rem_r[j-1][i][RW-2:0], low_r[j-1][i][QB-1]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (adv) begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          if (rt[i] >= RW'(d_r[j-1])) begin
            rem_r[j][i] <= rt[i] - RW'(d_r[j-1]);
            q_r[j][i]   <= {q_r[j-1][i][QB-2:0], 1'b1};
          end else begin
            rem_r[j][i] <= rt[i];
            q_r[j][i]   <= {q_r[j-1][i][QB-2:0], 1'b0};
          end
          low_r[j][i] <= low_r[j-1][i] << 1;
        end
        d_r[j]  <= d_r[j-1];
        sd_r[j] <= sd_r[j-1];
      end
    end
  end

  assign out_vld  = vld_r[QB];
  assign quo      = q_r[QB];
  assign out_side = sd_r[QB];

endmodule

>>> rtl/triangle_face_normal.sv
// triangle_face_normal: top level, unit face normal of one triangle per request
// depends on tfn_pkg, tfn_cross, tfn_align, tfn_sqrt, tfn_div
//
// usage
//   in channel: one triangle per request (three signed Q8.16 vertices plus
//   an end-of-mesh mark), taken when in_valid is high and in_stall is low
//   out channel: one normal per request in signed Q2.14 (1.0 = 16384),
//   rounded to nearest, plus the degenerate flag and the end-of-mesh copy
//   a triangle with an all-zero cross product comes out flagged degenerate
//   with a zero normal
// throughput and pipeline steps
//   one request per cycle sustained while no finished result is held
//   back by out_stall; the steps in order are edges, products, cross,
//   magnitude, leading-one search, alignment, squares, sum, square root
//   (one bit per stage), numerator, quotient bits (one per stage)
//   and the output register
// stall
//   the whole pipeline freezes while a finished result waits with
//   out_stall high; in_stall follows that same condition, so nothing is
//   dropped or repeated, and a bubble in the pipe is held, not squeezed out
// reset
//   rst_n low clears every valid bit; no request is in flight afterward

module triangle_face_normal
  import tfn_pkg::*;
#(
  parameter int COORD_BITS       = 24,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tri_req_t  in_req,
  output logic      out_valid,
  input  logic      out_stall,
  output nrm_req_t  out_req
);

  localparam int C  = COORD_BITS;
  localparam int F  = NORMAL_FRAC_BITS;
  localparam int MW = 2 * C + 3;          // exact cross product width
  localparam int QB = F + 1;              // quotient bits, value <= 2^F
  localparam int EW = (QB > NORMAL_W) ? QB : NORMAL_W;
  localparam int SQ_SW = 5 + 3 * ALIGN_W; // degenerate, signs, mesh mark, m

  // pipeline advances unless a finished result is held back
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // coordinate is the low COORD_BITS of its field, sign-extended;
  // a field narrower than COORD_BITS is taken unsigned
  logic [8:0][C-1:0] crd;
  logic [8:0][FIELD_W-1:0] fld;
  assign fld = {in_req.c_z, in_req.c_y, in_req.c_x,
                in_req.b_z, in_req.b_y, in_req.b_x,
                in_req.a_z, in_req.a_y, in_req.a_x};
  for (genvar i = 0; i < 9; i++) begin : g_crd
    if (C <= FIELD_W) begin : g_cut
      assign crd[i] = fld[i][C-1:0];
    end else begin : g_ext
      assign crd[i] = C'(fld[i]);
    end
  end

  // cross product and magnitudes
  logic               cr_vld;
  logic [2:0][MW-1:0] cr_mag;
  logic [2:0]         cr_neg;
  logic               cr_eom;

  tfn_cross #(.C(C), .MW(MW), .SW(1)) u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_valid),
    .crd      (crd),
    .in_side  (in_req.end_of_mesh),
    .out_vld  (cr_vld),
    .mag      (cr_mag),
    .neg      (cr_neg),
    .out_side (cr_eom)
  );

  // common alignment of the three magnitudes and their sum of squares
  logic                     al_vld;
  logic [2:0][ALIGN_W-1:0]  al_m;
  logic [SUMSQ_W-1:0]       al_sum;
  logic                     al_zero;
  logic [3:0]               al_side;

  tfn_align #(.MW(MW), .SW(4)) u_align (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (cr_vld),
    .mag      (cr_mag),
    .in_side  ({cr_neg, cr_eom}),
    .out_vld  (al_vld),
    .m        (al_m),
    .sum_sq   (al_sum),
    .zero     (al_zero),
    .out_side (al_side)
  );

  // vector length
  logic               sq_vld;
  logic [ROOT_W-1:0]  sq_root;
  logic [SQ_SW-1:0]   sq_side;

  tfn_sqrt #(.SW(SQ_SW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (al_vld),
    .sum_sq   (al_sum),
    .in_side  ({al_zero, al_side, al_m}),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .out_side (sq_side)
  );

  // per-component rounded quotient
  logic              dv_vld;
  logic [2:0][F:0]   dv_q;
  logic [4:0]        dv_side;

  tfn_div #(.F(F), .SW(5)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (sq_vld),
    .m        (sq_side[3*ALIGN_W-1:0]),
    .len      (sq_root),
    .in_side  (sq_side[SQ_SW-1 -: 5]),
    .out_vld  (dv_vld),
    .quo      (dv_q),
    .out_side (dv_side)
  );

  // side bits out of the divider: degenerate, signs z y x, mesh mark
  logic                    dv_degen, dv_eom;
  logic [2:0]              dv_neg;
  logic [2:0][EW-1:0]      qx;
  logic [2:0][NORMAL_W-1:0] nrm;
  assign dv_degen = dv_side[4];
  assign dv_neg   = dv_side[3:1];
  assign dv_eom   = dv_side[0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qx[i]  = EW'(dv_q[i]);
      if (dv_neg[i]) qx[i] = -qx[i];
      nrm[i] = dv_degen ? '0 : qx[i][NORMAL_W-1:0];
    end
  end

  // output register
  logic     out_valid_r;
  nrm_req_t out_req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_req_r.normal_x   <= nrm[0];
      out_req_r.normal_y   <= nrm[1];
      out_req_r.normal_z   <= nrm[2];
      out_req_r.degenerate <= dv_degen;
      out_req_r.mesh_done  <= dv_eom;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  // a degenerate triangle leaves with a zero normal
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.degenerate |->
      out_req.normal_x == '0 && out_req.normal_y == '0 && out_req.normal_z == '0)
    else $error("degenerate normal not zero");

  // a nonzero aligned vector has a length of at least 2^30
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld && !sq_side[SQ_SW-1] |-> sq_root[ROOT_W-1:ROOT_W-2] != 2'b00)
    else $error("vector length below alignment floor");

  // a frozen pipeline keeps the divider output in place
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv && dv_vld |=> dv_vld && $stable(dv_side))
    else $error("pipeline moved while frozen");

endmodule
